// File: hdl/cltq_pkg.sv
// ----------------------------------------------------------------------------
// cltq_pkg: shared types and constants for the command line token quoter
// Character codes, parse modes, keyword and prefix tables, and the queue
// entry that carries one beat's worth of expansion from front to back.
// ----------------------------------------------------------------------------
package cltq_pkg;

    localparam int DEPTH_MAX  = 255;
    localparam int DEPTH_W    = $clog2(DEPTH_MAX + 1);
    localparam int BODY_MAX   = 7;
    localparam int BCNT_W     = $clog2(BODY_MAX + 1);
    localparam int PREFIX_LEN = 8;
    localparam int IDX_W      = $clog2(PREFIX_LEN + BODY_MAX + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_T   = 8'h74;

    typedef enum logic [3:0] {
        MODE_BETWEEN  = 4'b0001,
        MODE_GROUP    = 4'b0010,
        MODE_QUOTED   = 4'b0100,
        MODE_UNQUOTED = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        GK_PAREN   = 2'd0,
        GK_BRACE   = 2'd1,
        GK_BRACKET = 2'd2
    } gkind_t;

    typedef struct packed {
        logic                          pfx;   // prefix goes out ahead of body
        logic                          done;  // last body byte closes the command
        logic [BCNT_W-1:0]             cnt;
        logic [BODY_MAX-1:0][7:0]      body;
    } cltq_entry_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = 8'h41; // A
            3'd1:    ch = 8'h49; // I
            3'd2:    ch = 8'h2F; // /
            3'd3:    ch = 8'h31; // 1
            3'd4:    ch = 8'h2E; // .
            3'd5:    ch = 8'h30; // 0
            3'd6:    ch = 8'h30; // 0
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] nil_char(input logic [1:0] i);
        logic [7:0] ch;
        case (i)
            2'd0:    ch = CH_LOW_N;
            2'd1:    ch = 8'h69;
            2'd2:    ch = 8'h6C;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] true_char(input logic [1:0] i);
        logic [7:0] ch;
        case (i)
            2'd0:    ch = CH_LOW_T;
            2'd1:    ch = 8'h72;
            2'd2:    ch = 8'h75;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] open_char(input gkind_t k);
        logic [7:0] ch;
        case (k)
            GK_BRACE:   ch = CH_LBRACE;
            GK_BRACKET: ch = CH_LBRACK;
            default:    ch = CH_LPAREN;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] close_char(input gkind_t k);
        logic [7:0] ch;
        case (k)
            GK_BRACE:   ch = CH_RBRACE;
            GK_BRACKET: ch = CH_RBRACK;
            default:    ch = CH_RPAREN;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/command_line_token_quoter.sv
// ----------------------------------------------------------------------------
// command_line_token_quoter: command text rewriter, top level
// Parser front, entry queue and byte serializer back.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one character per beat in tdata; tlast (or a zero byte) ends the
//   command. m_axis: one output character per beat in tdata; tlast marks the
//   final byte caused by an input beat, tuser the closing bar of a command.
//   Each input beat expands to 0..10 output bytes (the 8-byte prefix rides
//   on the first beat of a command). Beats that expand to nothing, such as
//   spaces between arguments, produce no output.
//   Throughput: one input beat per cycle while expansions stay at one byte;
//   the output side moves one byte per cycle, so a beat expanding to N bytes
//   holds the serializer until all N are out. A 4-entry queue decouples the two.
//   Reset clears the parse state and empties the queue. When the receiver
//   stalls, output holds; input keeps flowing until the queue fills, then
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module command_line_token_quoter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] command_done
);
    import cltq_pkg::*;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    cltq_entry_t q_in;
    cltq_entry_t q_head;

    cltq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    cltq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    cltq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser)
    );

endmodule

// File: hdl/cltq_front.sv
// ----------------------------------------------------------------------------
// cltq_front: parser and classifier
// Takes one input beat per cycle unless the queue is full, tracks the argument
// parse state and turns each beat with output into one entry listing its bytes.
// ----------------------------------------------------------------------------
module cltq_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_end,
    output logic                  in_ready,
    input  logic                  q_full,
    output logic                  push,
    output cltq_pkg::cltq_entry_t push_entry
);
    import cltq_pkg::*;

    mode_t              mode_reg, mode_next;
    logic               prefix_sent_reg, prefix_sent_next;
    gkind_t             gkind_reg, gkind_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               in_str_reg, in_str_next;
    logic               esc_reg, esc_next;
    logic               qla_reg, qla_next;
    logic               aq_reg, aq_next;
    logic               kc_reg, kc_next;
    logic [2:0]         hc_reg, hc_next;
    logic [7:0]         held_reg [4];
    logic [7:0]         held_next [4];

    logic                     accept;
    logic [BODY_MAX-1:0][7:0] bbuf;
    logic [BCNT_W-1:0]        bcnt;
    logic                     done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic [7:0] c;
        logic       at_end;
        logic       run_uq;
        logic       run_fin;
        logic       aq_e;
        logic       kc_e;
        logic [2:0] hc_e;
        logic [7:0] lc;
        logic [7:0] h0;
        logic       nil_ok;
        logic       true_ok;
        logic       keep;
        c       = in_byte;
        at_end  = in_end || (c == CH_NUL);
        run_uq  = 1'b0;
        run_fin = 1'b0;
        aq_e    = aq_reg;
        kc_e    = kc_reg;
        hc_e    = hc_reg;
        keep    = 1'b0;
        nil_ok  = 1'b0;
        true_ok = 1'b0;
        lc      = to_lower(c);
        h0      = to_lower(held_reg[0]);

        mode_next        = mode_reg;
        prefix_sent_next = 1'b1;
        gkind_next       = gkind_reg;
        depth_next       = depth_reg;
        in_str_next      = in_str_reg;
        esc_next         = esc_reg;
        qla_next         = qla_reg;
        aq_next          = aq_reg;
        kc_next          = kc_reg;
        hc_next          = hc_reg;
        held_next        = held_reg;
        bbuf             = '0;
        bcnt             = '0;
        done             = 1'b0;

        if (at_end) begin
            case (mode_reg)
                MODE_GROUP: begin
                    bbuf[bcnt] = CH_SPACE; bcnt = bcnt + 1'b1;
                end
                MODE_QUOTED: begin
                    bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                    bbuf[bcnt] = CH_SPACE; bcnt = bcnt + 1'b1;
                end
                MODE_UNQUOTED: run_fin = 1'b1;
                default: ;
            endcase
        end else begin
            case (mode_reg)
                MODE_GROUP: begin
                    bbuf[bcnt] = c; bcnt = bcnt + 1'b1;
                    if (in_str_reg) begin
                        if (esc_reg)
                            esc_next = 1'b0;
                        else if (c == CH_BSLASH)
                            esc_next = 1'b1;
                        else if (c == CH_QUOTE)
                            in_str_next = 1'b0;
                    end else if (c == CH_QUOTE) begin
                        in_str_next = 1'b1;
                    end else if (c == close_char(gkind_reg)) begin
                        depth_next = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;
                        if (depth_next == '0) begin
                            bbuf[bcnt] = CH_SPACE; bcnt = bcnt + 1'b1;
                            mode_next  = MODE_BETWEEN;
                        end
                    end else if (c == open_char(gkind_reg)) begin
                        if (depth_reg < DEPTH_W'(DEPTH_MAX))
                            depth_next = depth_reg + 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (c == CH_QUOTE) begin
                            bbuf[bcnt] = CH_BSLASH; bcnt = bcnt + 1'b1;
                            bbuf[bcnt] = CH_QUOTE;  bcnt = bcnt + 1'b1;
                            keep = 1'b1;
                        end else begin
                            bbuf[bcnt] = CH_BSLASH; bcnt = bcnt + 1'b1;
                            bbuf[bcnt] = CH_BSLASH; bcnt = bcnt + 1'b1;
                        end
                    end
                    if (!keep) begin
                        if (c == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                            bbuf[bcnt] = CH_SPACE; bcnt = bcnt + 1'b1;
                            mode_next  = MODE_BETWEEN;
                        end else begin
                            bbuf[bcnt] = c; bcnt = bcnt + 1'b1;
                        end
                    end
                    keep = 1'b0;
                end
                MODE_UNQUOTED: begin
                    if (c == CH_SPACE)
                        run_fin = 1'b1;
                    else
                        run_uq = 1'b1;
                end
                MODE_BETWEEN: begin
                    if (c == CH_LPAREN || c == CH_LBRACE || c == CH_LBRACK) begin
                        gkind_next  = (c == CH_LBRACE) ? GK_BRACE :
                                      (c == CH_LBRACK) ? GK_BRACKET : GK_PAREN;
                        depth_next  = DEPTH_W'(1);
                        in_str_next = 1'b0;
                        esc_next    = 1'b0;
                        bbuf[bcnt]  = c; bcnt = bcnt + 1'b1;
                        mode_next   = MODE_GROUP;
                    end else if (c == CH_QUOTE) begin
                        esc_next   = 1'b0;
                        bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                        mode_next  = MODE_QUOTED;
                    end else if (c != CH_SPACE) begin
                        // bare argument: wrap later ones unless they lead with a digit
                        aq_e      = qla_reg && !(c inside {[8'h30:8'h39]});
                        kc_e      = aq_e;
                        hc_e      = 3'd0;
                        aq_next   = aq_e;
                        kc_next   = aq_e;
                        hc_next   = 3'd0;
                        mode_next = MODE_UNQUOTED;
                        run_uq    = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (run_uq) begin
            nil_ok  = (hc_e < 3'd3) && (lc == nil_char(hc_e[1:0])) &&
                      ((hc_e == 3'd0) || (h0 == CH_LOW_N));
            true_ok = (hc_e < 3'd4) && (lc == true_char(hc_e[1:0])) &&
                      ((hc_e == 3'd0) || (h0 == CH_LOW_T));
            if (aq_e && kc_e) begin
                if (hc_e < 3'd4) begin
                    held_next[hc_e[1:0]] = c;
                    if (nil_ok || true_ok) begin
                        hc_next = hc_e + 1'b1;
                        keep    = 1'b1;
                    end
                end
                if (!keep) begin
                    // can no longer spell a keyword: release what was held
                    bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < hc_e) begin
                            bbuf[bcnt] = held_reg[i]; bcnt = bcnt + 1'b1;
                        end
                    end
                    hc_next = 3'd0;
                    kc_next = 1'b0;
                end
            end
            if (!keep) begin
                if (c == CH_BSLASH) begin
                    bbuf[bcnt] = CH_BSLASH; bcnt = bcnt + 1'b1;
                end
                bbuf[bcnt] = c; bcnt = bcnt + 1'b1;
            end
        end

        if (run_fin) begin
            if (aq_e) begin
                if (kc_e && hc_e == 3'd3 && h0 == CH_LOW_N) begin
                    for (int i = 0; i < 3; i++) begin
                        bbuf[bcnt] = nil_char(2'(i)); bcnt = bcnt + 1'b1;
                    end
                end else if (kc_e && hc_e == 3'd4) begin
                    for (int i = 0; i < 4; i++) begin
                        bbuf[bcnt] = true_char(2'(i)); bcnt = bcnt + 1'b1;
                    end
                end else begin
                    if (kc_e) begin
                        bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            if (3'(i) < hc_e) begin
                                bbuf[bcnt] = held_reg[i]; bcnt = bcnt + 1'b1;
                            end
                        end
                    end
                    bbuf[bcnt] = CH_QUOTE; bcnt = bcnt + 1'b1;
                end
            end
            bbuf[bcnt] = CH_SPACE; bcnt = bcnt + 1'b1;
            hc_next   = 3'd0;
            kc_next   = 1'b0;
            aq_next   = 1'b0;
            qla_next  = 1'b1;
            mode_next = MODE_BETWEEN;
        end

        if (at_end) begin
            bbuf[bcnt]       = CH_BAR; bcnt = bcnt + 1'b1;
            done             = 1'b1;
            mode_next        = MODE_BETWEEN;
            prefix_sent_next = 1'b0;
            gkind_next       = GK_PAREN;
            depth_next       = '0;
            in_str_next      = 1'b0;
            esc_next         = 1'b0;
            qla_next         = 1'b0;
            aq_next          = 1'b0;
            kc_next          = 1'b0;
            hc_next          = 3'd0;
        end
    end

    assign push_entry.pfx  = !prefix_sent_reg;
    assign push_entry.done = done;
    assign push_entry.cnt  = bcnt;
    assign push_entry.body = bbuf;
    assign push = accept && (!prefix_sent_reg || bcnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_BETWEEN;
            prefix_sent_reg <= 1'b0;
            gkind_reg       <= GK_PAREN;
            depth_reg       <= '0;
            in_str_reg      <= 1'b0;
            esc_reg         <= 1'b0;
            qla_reg         <= 1'b0;
            aq_reg          <= 1'b0;
            kc_reg          <= 1'b0;
            hc_reg          <= 3'd0;
        end else if (accept) begin
            mode_reg        <= mode_next;
            prefix_sent_reg <= prefix_sent_next;
            gkind_reg       <= gkind_next;
            depth_reg       <= depth_next;
            in_str_reg      <= in_str_next;
            esc_reg         <= esc_next;
            qla_reg         <= qla_next;
            aq_reg          <= aq_next;
            kc_reg          <= kc_next;
            hc_reg          <= hc_next;
        end
    end

    // held bytes are only read below hc_reg, so no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// File: hdl/cltq_fifo.sv
// ----------------------------------------------------------------------------
// cltq_fifo: entry queue between parser and serializer
// Small register queue; lets the parser keep taking beats while the
// serializer drains a multi-byte expansion.
// ----------------------------------------------------------------------------
module cltq_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cltq_pkg::cltq_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output cltq_pkg::cltq_entry_t head
);
    import cltq_pkg::*;

    cltq_entry_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/cltq_back.sv
// ----------------------------------------------------------------------------
// cltq_back: byte serializer
// Walks the head queue entry one output beat per cycle while out_ready is high:
// prefix bytes first when flagged, then the body bytes; pops it on its last beat.
// ----------------------------------------------------------------------------
module cltq_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  cltq_pkg::cltq_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic                  out_done
);
    import cltq_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] off;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] bpos;
    logic             take;

    assign off   = head.pfx ? IDX_W'(PREFIX_LEN) : '0;
    assign total = off + IDX_W'(head.cnt);
    assign bpos  = idx_reg - off;

    assign out_valid = !q_empty;
    assign out_last  = (idx_reg == total - 1'b1);
    assign out_done  = head.done && out_last;
    assign out_byte  = (head.pfx && idx_reg < IDX_W'(PREFIX_LEN))
                     ? prefix_char(idx_reg[2:0])
                     : head.body[bpos[BCNT_W-1:0]];

    assign take = out_valid && out_ready;
    assign pop  = take && out_last;

    always_comb begin
        idx_next = idx_reg;
        if (take)
            idx_next = out_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// File: hdl/cltq_checker.sv
// ----------------------------------------------------------------------------
// cltq_checker: port-level checks for the token quoter
// Watches the top-level stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module cltq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);
    import cltq_pkg::*;

    // command end beat is the bar and closes its run
    a_done_is_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == CH_BAR))
        else $error("command_done beat is not a closing bar");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked right after reset");

    // a command end accepted with nothing queued yields output next cycle
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tdata == CH_NUL)
        && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("end of command produced no output");

endmodule

bind command_line_token_quoter cltq_checker u_cltq_checker (.*);
